// ----- src/kbet_pkg.sv -----
// Shared types, codes and state-transition functions of the key/button edge tracker.
package kbet_pkg;

	// Per-entry tracking state
	typedef enum logic [2:0] {
		ST_UP       = 3'd0,
		ST_PRESSED  = 3'd1,
		ST_DOWN     = 3'd2,
		ST_RELEASED = 3'd3,
		ST_PRESSREL = 3'd4,
		ST_DRAG     = 3'd5
	} st_t;

	// Request modes
	typedef enum logic [2:0] {
		MD_KEY_PRESS   = 3'd0,
		MD_KEY_RELEASE = 3'd1,
		MD_MOVE        = 3'd2,
		MD_BTN_PRESS   = 3'd3,
		MD_BTN_RELEASE = 3'd4,
		MD_FOCUS_LOST  = 3'd5,
		MD_TICK        = 3'd6,
		MD_QUERY       = 3'd7
	} mode_t;

	// Register indexes
	localparam logic [1:0] REG_THRESH = 2'd0;
	localparam logic [1:0] REG_HOME_X = 2'd1;
	localparam logic [1:0] REG_HOME_Y = 2'd2;

	localparam int CFG_AW = 4;

	localparam logic [7:0]  THRESH_RST = 8'd5;
	localparam logic [11:0] HOME_X_RST = 12'd320;
	localparam logic [11:0] HOME_Y_RST = 12'd240;

	localparam int         BUTTONS    = 3;
	localparam logic [1:0] BTN_LEFT   = 2'd0;
	localparam logic [1:0] BTN_MIDDLE = 2'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [8:0]  key_index;
		logic [1:0]  button_index;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
	} req_t;

	typedef struct packed {
		logic        key_is_down;
		logic        key_went_down;
		logic        key_went_up;
		logic        button_is_down;
		logic        button_went_down;
		logic        button_went_up;
		logic        button_dragging;
		logic [11:0] drag_x;
		logic [11:0] drag_y;
		logic [11:0] mouse_x;
		logic [11:0] mouse_y;
	} res_t;

	// Register file contents
	typedef struct packed {
		logic [7:0]  drag_limit;
		logic [11:0] home_x;
		logic [11:0] home_y;
	} cfg_t;

	// Recentre strobes raised by a home register write
	typedef struct packed {
		logic        set_x;
		logic        set_y;
		logic [11:0] x;
		logic [11:0] y;
	} ctr_t;

	// Event handed to the pointer/button unit at accept
	typedef struct packed {
		logic        valid;
		logic [2:0]  mode;
		logic [1:0]  btn;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
	} evt_t;

	// Button flags and positions reported by the pointer/button unit
	typedef struct packed {
		logic        is_down;
		logic        went_down;
		logic        went_up;
		logic        dragging;
		logic [11:0] drag_x;
		logic [11:0] drag_y;
		logic [11:0] mouse_x;
		logic [11:0] mouse_y;
	} ptr_t;

	function automatic st_t on_press(st_t s);
		if (s inside {ST_UP, ST_RELEASED, ST_PRESSREL}) begin
			return ST_PRESSED;
		end
		return s;
	endfunction

	function automatic st_t on_release(st_t s);
		if (s == ST_PRESSED) begin
			return ST_PRESSREL;
		end
		if (s inside {ST_DOWN, ST_DRAG}) begin
			return ST_RELEASED;
		end
		return s;
	endfunction

	function automatic st_t on_tick(st_t s);
		if (s == ST_PRESSED) begin
			return ST_DOWN;
		end
		if (s inside {ST_RELEASED, ST_PRESSREL}) begin
			return ST_UP;
		end
		return s;
	endfunction

	function automatic st_t on_focus_lost(st_t s);
		if (s inside {ST_PRESSED, ST_DOWN, ST_DRAG}) begin
			return ST_RELEASED;
		end
		return s;
	endfunction

	function automatic logic went_down(st_t s);
		return (s == ST_PRESSED) || (s == ST_PRESSREL);
	endfunction

	function automatic logic went_up(st_t s);
		return (s == ST_RELEASED) || (s == ST_PRESSREL);
	endfunction

endpackage

// ----- src/kbet_key_ram.sv -----
// Key state memory: one write port, one read port with registered data.
module kbet_key_ram import kbet_pkg::*; #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  st_t           wdata,
	input  logic [AW-1:0] raddr,
	output st_t           rdata
);

	st_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/kbet_cfg.sv -----
// APB register file: drag threshold and home position, with recentre strobes.
module kbet_cfg import kbet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg,
	output ctr_t              ctr
);

	cfg_t       cfg_q;
	logic       wr;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[CFG_AW-1:2];
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	assign ctr.set_x = wr && (idx == REG_HOME_X);
	assign ctr.set_y = wr && (idx == REG_HOME_Y);
	assign ctr.x     = pwdata[11:0];
	assign ctr.y     = pwdata[11:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drag_limit <= THRESH_RST;
			cfg_q.home_x     <= HOME_X_RST;
			cfg_q.home_y     <= HOME_Y_RST;
		end else if (wr) begin
			case (idx)
				REG_THRESH: cfg_q.drag_limit <= pwdata[7:0];
				REG_HOME_X: cfg_q.home_x     <= pwdata[11:0];
				REG_HOME_Y: cfg_q.home_y     <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_THRESH: prdata = {24'd0, cfg_q.drag_limit};
			REG_HOME_X: prdata = {20'd0, cfg_q.home_x};
			REG_HOME_Y: prdata = {20'd0, cfg_q.home_y};
			default:    prdata = 32'd0;
		endcase
	end

endmodule

// ----- src/kbet_ptr.sv -----
// Pointer buttons, drag start and stored pointer position.
module kbet_ptr import kbet_pkg::*; #(
	parameter int POS_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  evt_t       evt,
	input  logic [1:0] query_btn,
	input  cfg_t       cfg,
	input  ctr_t       ctr,
	output ptr_t       ptr
);

	st_t                 btn_q [BUTTONS];
	logic [1:0]          drag_btn_q;
	logic [POS_BITS-1:0] dsx_q, dsy_q, px_q, py_q;
	logic [POS_BITS-1:0] px_in, py_in, dx, dy, thr;
	logic                far, evt_btn_ok;
	st_t                 ds, bs;

	always_comb begin
		px_in      = POS_BITS'(evt.pos_x);
		py_in      = POS_BITS'(evt.pos_y);
		dx         = (dsx_q > px_in) ? dsx_q - px_in : px_in - dsx_q;
		dy         = (dsy_q > py_in) ? dsy_q - py_in : py_in - dsy_q;
		thr        = POS_BITS'(cfg.drag_limit);
		far        = (dx > thr) || (dy > thr);
		ds         = btn_q[drag_btn_q];
		evt_btn_ok = (evt.btn < 2'(BUTTONS));
		bs         = (query_btn < 2'(BUTTONS)) ? btn_q[query_btn] : ST_UP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTONS; i++) begin
				btn_q[i] <= ST_UP;
			end
			drag_btn_q <= BTN_LEFT;
			dsx_q      <= POS_BITS'(HOME_X_RST);
			px_q       <= POS_BITS'(HOME_X_RST);
			dsy_q      <= POS_BITS'(HOME_Y_RST);
			py_q       <= POS_BITS'(HOME_Y_RST);
		end else begin
			if (ctr.set_x) begin
				dsx_q <= POS_BITS'(ctr.x);
				px_q  <= POS_BITS'(ctr.x);
			end
			if (ctr.set_y) begin
				dsy_q <= POS_BITS'(ctr.y);
				py_q  <= POS_BITS'(ctr.y);
			end
			if (evt.valid) begin
				case (evt.mode)
					MD_MOVE: begin
						// pointer is frozen while the middle button is not in the up state
						if (btn_q[BTN_MIDDLE] == ST_UP) begin
							px_q <= px_in;
							py_q <= py_in;
							if ((ds == ST_PRESSED || ds == ST_DOWN) && far) begin
								btn_q[drag_btn_q] <= ST_DRAG;
							end
						end
					end
					MD_BTN_PRESS: begin
						if (evt_btn_ok &&
							(btn_q[evt.btn] inside {ST_UP, ST_RELEASED, ST_PRESSREL})) begin
							btn_q[evt.btn] <= ST_PRESSED;
							drag_btn_q     <= evt.btn;
							dsx_q          <= px_q;
							dsy_q          <= py_q;
						end
					end
					MD_BTN_RELEASE: begin
						if (evt_btn_ok) begin
							btn_q[evt.btn] <= on_release(btn_q[evt.btn]);
						end
					end
					MD_FOCUS_LOST: begin
						for (int i = 0; i < BUTTONS; i++) begin
							btn_q[i] <= on_focus_lost(btn_q[i]);
						end
					end
					MD_TICK: begin
						for (int i = 0; i < BUTTONS; i++) begin
							btn_q[i] <= on_tick(btn_q[i]);
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign ptr.is_down   = (bs != ST_UP);
	assign ptr.went_down = went_down(bs);
	assign ptr.went_up   = went_up(bs);
	assign ptr.dragging  = (bs == ST_DRAG);
	assign ptr.drag_x    = 12'(dsx_q);
	assign ptr.drag_y    = 12'(dsy_q);
	assign ptr.mouse_x   = 12'(px_q);
	assign ptr.mouse_y   = 12'(py_q);

endmodule

// ----- src/key_button_edge_tracker_unit.sv -----
// Top level of the key/button edge tracker: sequencer around the key state memory.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   in       | in_valid, in_stall | in_req  (mode, key, button, position)
//   out      | out_valid, out_stall | out_res (key/button flags, positions)
//   config   | APB psel/penable   | drag limit, home_x, home_y
//
// Key press and release requests do one key memory read, then modify and write
// back; button, move and query requests only read. Frame tick and focus lost
// sweep all keys, one key entry per cycle through the memory read port.
// After reset a clearing pass writes every key to up; in_stall stays high during
// it. A finished result waits in the output register; the next request is
// accepted meanwhile and completes once that result is taken.
module key_button_edge_tracker_unit import kbet_pkg::*; #(
	parameter int KEY_COUNT = 512,
	parameter int POS_BITS  = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  req_t              in_req,
	output logic              out_valid,
	input  logic              out_stall,
	output res_t              out_res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int KW = $clog2(KEY_COUNT);
	localparam int XW = ((KW > 9) ? KW : 9) + 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RMW,
		S_SWEEP,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t          state_q;
	logic [KW-1:0]   cnt_q;
	req_t            req_q;
	logic            key_ok_q;
	logic [KW-1:0]   key_addr_q;
	st_t             ks_q;
	logic            sweep_v_s1;
	logic [KW-1:0]   sweep_addr_s1;
	logic            out_valid_q;
	res_t            out_q;

	logic            accept, out_free, out_load, in_ok, sweep_hit;
	logic [XW-1:0]   key_ext_in;
	logic            key_we;
	logic [KW-1:0]   waddr, raddr;
	st_t             wdata, rd_data, rmw_new, sweep_new, ks_now;
	res_t            res_next;
	cfg_t            cfg;
	ctr_t            ctr;
	evt_t            evt;
	ptr_t            ptr;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && (state_q inside {S_RMW, S_DRAIN, S_FIN});

	assign key_ext_in = XW'(in_req.key_index);
	assign in_ok      = (key_ext_in < XW'(KEY_COUNT));

	assign evt.valid = accept;
	assign evt.mode  = in_req.mode;
	assign evt.btn   = in_req.button_index;
	assign evt.pos_x = in_req.pos_x;
	assign evt.pos_y = in_req.pos_y;

	always_comb begin
		case (req_q.mode)
			MD_KEY_PRESS:   rmw_new = on_press(rd_data);
			MD_KEY_RELEASE: rmw_new = on_release(rd_data);
			default:        rmw_new = rd_data;
		endcase
		sweep_new = (req_q.mode == MD_FOCUS_LOST) ? on_focus_lost(rd_data) : on_tick(rd_data);
		sweep_hit = sweep_v_s1 && key_ok_q && (sweep_addr_s1 == key_addr_q);

		key_we = 1'b0;
		waddr  = key_addr_q;
		wdata  = rmw_new;
		if (state_q == S_CLEAR) begin
			key_we = 1'b1;
			waddr  = cnt_q;
			wdata  = ST_UP;
		end else if (sweep_v_s1) begin
			key_we = 1'b1;
			waddr  = sweep_addr_s1;
			wdata  = sweep_new;
		end else if (state_q == S_RMW) begin
			key_we = key_ok_q &&
				(req_q.mode == MD_KEY_PRESS || req_q.mode == MD_KEY_RELEASE);
		end

		case (state_q)
			S_IDLE:  raddr = key_ext_in[KW-1:0];
			S_SWEEP: raddr = cnt_q;
			default: raddr = key_addr_q;
		endcase

		case (state_q)
			S_RMW:   ks_now = key_ok_q ? rmw_new : ST_UP;
			S_DRAIN: ks_now = sweep_hit ? sweep_new : ks_q;
			default: ks_now = ks_q;
		endcase

		res_next.key_is_down      = (ks_now != ST_UP);
		res_next.key_went_down    = went_down(ks_now);
		res_next.key_went_up      = went_up(ks_now);
		res_next.button_is_down   = ptr.is_down;
		res_next.button_went_down = ptr.went_down;
		res_next.button_went_up   = ptr.went_up;
		res_next.button_dragging  = ptr.dragging;
		res_next.drag_x           = ptr.drag_x;
		res_next.drag_y           = ptr.drag_y;
		res_next.mouse_x          = ptr.mouse_x;
		res_next.mouse_y          = ptr.mouse_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			sweep_v_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sweep_v_s1    <= (state_q == S_SWEEP);
			sweep_addr_s1 <= cnt_q;
			if (out_load) begin
				out_q       <= res_next;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == KW'(KEY_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						req_q      <= in_req;
						key_ok_q   <= in_ok;
						key_addr_q <= key_ext_in[KW-1:0];
						ks_q       <= ST_UP;
						cnt_q      <= '0;
						if (in_req.mode == MD_FOCUS_LOST || in_req.mode == MD_TICK) begin
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_RMW;
						end
					end
				end
				S_SWEEP: begin
					if (sweep_hit) begin
						ks_q <= sweep_new;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == KW'(KEY_COUNT - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_RMW, S_DRAIN: begin
					ks_q <= ks_now;
					if (out_free) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	kbet_key_ram #(
		.DEPTH(KEY_COUNT),
		.AW   (KW)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	kbet_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg),
		.ctr    (ctr)
	);

	kbet_ptr #(
		.POS_BITS(POS_BITS)
	) u_ptr (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.query_btn(req_q.button_index),
		.cfg      (cfg),
		.ctr      (ctr),
		.ptr      (ptr)
	);

	// sweep write-back never targets the entry being read in the same cycle
	a_sweep_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(sweep_v_s1 && state_q == S_SWEEP) |-> (sweep_addr_s1 != cnt_q))
		else $error("sweep read and write-back hit the same key entry");

	// a result only appears at the end of a request
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RMW || $past(state_q) == S_DRAIN ||
			$past(state_q) == S_FIN))
		else $error("result raised outside request completion");

	// nothing is in flight during the post-reset clearing pass
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!out_valid_q && !sweep_v_s1))
		else $error("activity during key memory clearing pass");

endmodule
